// File: rtl/ffsa_pkg.sv
package ffsa_pkg;

  localparam int MAX_SEG = 32;
  localparam int IDX_W   = $clog2(MAX_SEG);
  localparam int CNT_W   = $clog2(MAX_SEG + 1);
  localparam int AW      = 16;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_LOAD   = 4'd1;
  localparam logic [3:0] CMD_STEP_F = 4'd2;
  localparam logic [3:0] CMD_STEP_U = 4'd3;
  localparam logic [3:0] CMD_PASS_F = 4'd4;
  localparam logic [3:0] CMD_GRAB_U = 4'd5;
  localparam logic [3:0] CMD_TAKE   = 4'd6;
  localparam logic [3:0] CMD_INS_U  = 4'd7;
  localparam logic [3:0] CMD_MERGE  = 4'd8;

  typedef struct packed {
    logic [3:0]    op;
    logic [AW-1:0] amount;
    logic [AW-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic          amt_zero;
    logic          f_end;
    logic          f_fit;
    logic          f_lt;
    logic          f_full;
    logic          u_end;
    logic          u_lt;
    logic          u_hit;
    logic          u_full;
    logic          pm;
    logic          sm;
    logic [AW-1:0] st;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] used_count;
  } stat_t;

endpackage

// File: rtl/ffsa_datapath.sv
module ffsa_datapath import ffsa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [AW-1:0] cfg_data,
  input  cmd_t          cmd,
  output stat_t         stat
);

  logic [AW-1:0]    fs [MAX_SEG];
  logic [AW-1:0]    fl [MAX_SEG];
  logic [AW-1:0]    us [MAX_SEG];
  logic [AW-1:0]    ul [MAX_SEG];
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] used_count;
  logic [CNT_W-1:0] fi;
  logic [CNT_W-1:0] ui;
  logic [AW-1:0]    amt;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    st;
  logic [AW-1:0]    ln;
  logic [AW:0]      prev_end;
  logic [AW-1:0]    prev_len;

  logic [AW-1:0] fs_rd, fl_rd, us_rd, ul_rd;
  logic [CNT_W-1:0] fi_prev;

  assign fs_rd   = fs[fi[IDX_W-1:0]];
  assign fl_rd   = fl[fi[IDX_W-1:0]];
  assign us_rd   = us[ui[IDX_W-1:0]];
  assign ul_rd   = ul[ui[IDX_W-1:0]];
  assign fi_prev = fi - CNT_W'(1);

  always_comb begin
    stat.amt_zero   = (amt == '0);
    stat.f_end      = (fi == free_count);
    stat.f_fit      = (fl_rd >= amt);
    stat.f_lt       = (fs_rd < st);
    stat.f_full     = (free_count == CNT_W'(MAX_SEG));
    stat.u_end      = (ui == used_count);
    stat.u_lt       = (us_rd < st);
    stat.u_hit      = (us_rd == addr);
    stat.u_full     = (used_count == CNT_W'(MAX_SEG));
    stat.pm         = (fi != '0) && (prev_end == {1'b0, st});
    stat.sm         = (fi != free_count) && (({1'b0, st} + {1'b0, ln}) == {1'b0, fs_rd});
    stat.st         = st;
    stat.free_count = free_count;
    stat.used_count = used_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= CNT_W'(1);
      used_count <= '0;
      fs[0]      <= '0;
      fl[0]      <= AW'(1024);
      fi         <= '0;
      ui         <= '0;
    end else if (cfg_we) begin
      free_count <= (cfg_data != '0) ? CNT_W'(1) : '0;
      used_count <= '0;
      fs[0]      <= '0;
      fl[0]      <= cfg_data;
    end else begin
      case (cmd.op)
        CMD_LOAD: begin
          amt  <= cmd.amount;
          addr <= cmd.addr;
          st   <= cmd.addr;
          fi   <= '0;
          ui   <= '0;
        end
        CMD_STEP_F: fi <= fi + CNT_W'(1);
        CMD_STEP_U: ui <= ui + CNT_W'(1);
        CMD_PASS_F: begin
          prev_end <= {1'b0, fs_rd} + {1'b0, fl_rd};
          prev_len <= fl_rd;
          fi       <= fi + CNT_W'(1);
        end
        CMD_GRAB_U: begin
          st <= us_rd;
          ln <= ul_rd;
        end
        CMD_TAKE: begin
          st <= fs_rd;
          ui <= '0;
          if (fl_rd == amt) begin
            for (int j = 0; j < MAX_SEG - 1; j++) begin
              if (CNT_W'(j) >= fi) begin
                fs[j] <= fs[j+1];
                fl[j] <= fl[j+1];
              end
            end
            free_count <= free_count - CNT_W'(1);
          end else begin
            fs[fi[IDX_W-1:0]] <= fs_rd + amt;
            fl[fi[IDX_W-1:0]] <= fl_rd - amt;
          end
        end
        CMD_INS_U: begin
          for (int j = 1; j < MAX_SEG; j++) begin
            if (CNT_W'(j) > ui) begin
              us[j] <= us[j-1];
              ul[j] <= ul[j-1];
            end
          end
          us[ui[IDX_W-1:0]] <= st;
          ul[ui[IDX_W-1:0]] <= amt;
          used_count <= used_count + CNT_W'(1);
        end
        CMD_MERGE: begin
          // Drop the released entry from the allocated table.
          for (int j = 0; j < MAX_SEG - 1; j++) begin
            if (CNT_W'(j) >= ui) begin
              us[j] <= us[j+1];
              ul[j] <= ul[j+1];
            end
          end
          used_count <= used_count - CNT_W'(1);
          if (stat.pm && stat.sm) begin
            for (int j = 0; j < MAX_SEG - 1; j++) begin
              if (CNT_W'(j) >= fi) begin
                fs[j] <= fs[j+1];
                fl[j] <= fl[j+1];
              end
            end
            fl[fi_prev[IDX_W-1:0]] <= prev_len + ln + fl_rd;
            free_count <= free_count - CNT_W'(1);
          end else if (stat.pm) begin
            fl[fi_prev[IDX_W-1:0]] <= prev_len + ln;
          end else if (stat.sm) begin
            fs[fi[IDX_W-1:0]] <= st;
            fl[fi[IDX_W-1:0]] <= fl_rd + ln;
          end else begin
            for (int j = 1; j < MAX_SEG; j++) begin
              if (CNT_W'(j) > fi) begin
                fs[j] <= fs[j-1];
                fl[j] <= fl[j-1];
              end
            end
            fs[fi[IDX_W-1:0]] <= st;
            fl[fi[IDX_W-1:0]] <= ln;
            free_count <= free_count + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ffsa_ctrl.sv
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic [1:0]    m_tuser,
  output cmd_t          cmd,
  input  stat_t         stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACHK = 3'd1;
  localparam logic [2:0] S_AFS  = 3'd2;
  localparam logic [2:0] S_AUS  = 3'd3;
  localparam logic [2:0] S_RUS  = 3'd4;
  localparam logic [2:0] S_RFS  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] res, res_next;
  logic       rel;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd.op     = CMD_NONE;
    cmd.amount = s_tdata[15:0];
    cmd.addr   = s_tdata[31:16];
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = CMD_LOAD;
          state_next = (s_tuser == FUNC_RELEASE) ? S_RUS : S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat.amt_zero) begin
          res_next = ST_NO_FIT; state_next = S_WAIT;
        end else begin
          state_next = S_AFS;
        end
      end
      S_AFS: begin
        if (stat.f_end) begin
          res_next = ST_NO_FIT; state_next = S_WAIT;
        end else if (stat.f_fit) begin
          if (stat.u_full) begin
            res_next = ST_FULL; state_next = S_WAIT;
          end else begin
            cmd.op = CMD_TAKE; state_next = S_AUS;
          end
        end else begin
          cmd.op = CMD_STEP_F;
        end
      end
      S_AUS: begin
        if (!stat.u_end && stat.u_lt) begin
          cmd.op = CMD_STEP_U;
        end else begin
          cmd.op = CMD_INS_U; res_next = ST_DONE; state_next = S_WAIT;
        end
      end
      S_RUS: begin
        if (stat.u_end) begin
          res_next = ST_NOT_FOUND; state_next = S_WAIT;
        end else if (stat.u_hit) begin
          cmd.op = CMD_GRAB_U; state_next = S_RFS;
        end else begin
          cmd.op = CMD_STEP_U;
        end
      end
      S_RFS: begin
        if (!stat.f_end && stat.f_lt) begin
          cmd.op = CMD_PASS_F;
        end else if (!stat.pm && !stat.sm && stat.f_full) begin
          res_next = ST_FULL; state_next = S_WAIT;
        end else begin
          cmd.op = CMD_MERGE; res_next = ST_DONE; state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      res      <= ST_DONE;
      rel      <= 1'b0;
    end else begin
      state <= state_next;
      res   <= res_next;
      if (state == S_IDLE && s_tvalid) rel <= (s_tuser == FUNC_RELEASE);
      if (state == S_WAIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tuser  <= res;
        // Only a granted allocation reports a start address.
        m_tdata  <= (res == ST_DONE && !rel) ? stat.st : '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/first_fit_segment_allocator.sv
// Channel   Dir  tdata                                 tuser
// s_        in   [15:0] amount, [31:16] release_start  [0] func
// m_        out  [15:0] granted_start                  [1:0] status
// cfg_      in   cfg_data = memory_size, written when cfg_we is high
//
// An allocate walks the free table and then the allocated table, a release
// the allocated table and then the free table, over the entries it must pass;
// the single read port of each table sets this. The next request can be
// accepted as soon as the result is loaded.
// rst (synchronous) leaves one free segment [0, 1024) and no allocations.
// A finished result waits in the output register while the next request
// is accepted; a held result stalls only the end of the following one.
module first_fit_segment_allocator import ffsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] amount, [31:16] release_start
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] granted_start
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  ffsa_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cmd, .stat
  );

  ffsa_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .cmd, .stat
  );

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_DONE |-> m_tdata == '0)
    else $error("granted_start nonzero on a failed request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    stat.free_count <= CNT_W'(MAX_SEG) && stat.used_count <= CNT_W'(MAX_SEG))
    else $error("table count overflow");

endmodule
